### hw/rtl/ncc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncc_pkg;

	// fixed field widths of the point, result and control channels
	localparam int COORD_W   = 16;
	localparam int DEPTH_W   = 15;
	localparam int COUNT_W   = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 15;

	// values after reset of the two control registers
	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = 15'd5000;
	localparam logic [DEPTH_W-1:0] WINDOW_RST    = 15'd50;

	// pass selector carried by every point
	typedef enum logic {
		OP_SEARCH = 1'b0,
		OP_ACCUM  = 1'b1
	} opcode_t;

	// control register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_DEPTH = 1'b0,
		REG_WINDOW    = 1'b1
	} reg_idx_t;

	// control registers as seen by the point path
	typedef struct packed {
		logic [DEPTH_W-1:0] max_depth;
		logic [DEPTH_W-1:0] window;
	} cfg_t;

endpackage

`default_nettype wire

### hw/rtl/ncc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// point stream channel
interface ncc_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] point_z;
	logic               opcode;
	logic               last_of_pass;

	modport source (
		output valid, point_x, point_y, point_z, opcode, last_of_pass,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, opcode, last_of_pass,
		output ready
	);
endinterface

// centroid result channel
interface ncc_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] centroid_x;
	logic signed [15:0] centroid_y;
	logic signed [15:0] centroid_z;
	logic        [19:0] point_count;
	logic        [14:0] nearest_depth;
	logic               valid_res;

	modport source (
		output valid, centroid_x, centroid_y, centroid_z, point_count,
		       nearest_depth, valid_res,
		input  ready
	);
	modport sink (
		input  valid, centroid_x, centroid_y, centroid_z, point_count,
		       nearest_depth, valid_res,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/ncc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_front import ncc_pkg::*; #(
	parameter int MAX_POINTS = 524288,
	parameter int CNT_W      = 20,
	parameter int SUM_W      = 35,
	parameter int JOB_W      = 3 * 35 + 20 + 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	ncc_point_if.sink             points,
	output logic                  job_valid,
	output logic [JOB_W-1:0]      job_data,
	input  wire logic             job_ready
);

	logic                    found_q;
	logic [DEPTH_W-1:0]      nearest_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    xfer;
	logic [DEPTH_W-1:0]      near_cur;
	logic signed [17:0]      z_e, near_e, hi_e, lo_e;
	logic                    is_accum;
	logic                    search_hit;
	logic                    take;
	logic                    frame_end;
	logic signed [SUM_W-1:0] sum_x_n, sum_y_n, sum_z_n;
	logic [CNT_W-1:0]        cnt_n;

	assign points.ready = job_ready;
	assign xfer         = points.valid && points.ready;
	assign is_accum     = (opcode_t'(points.opcode) == OP_ACCUM);

	// nearest depth follows max_depth until a search point lowers it
	assign near_cur = found_q ? nearest_q : cfg.max_depth;

	// depth comparisons on an 18 bit signed range
	assign z_e    = 18'(points.point_z);
	assign near_e = $signed({3'b000, near_cur});
	assign hi_e   = near_e + $signed({3'b000, cfg.window});
	assign lo_e   = near_e - $signed({3'b000, cfg.window});

	assign search_hit = !is_accum && (points.point_z > 16'sd0) && (z_e < near_e);
	assign take       = is_accum && (z_e < hi_e) && (z_e > lo_e)
	                    && (cnt_q < CNT_W'(MAX_POINTS));
	assign frame_end  = is_accum && points.last_of_pass;

	// running sums including the current point
	always_comb begin
		sum_x_n = sum_x_q;
		sum_y_n = sum_y_q;
		sum_z_n = sum_z_q;
		cnt_n   = cnt_q;
		if (take) begin
			sum_x_n = sum_x_q + SUM_W'(points.point_x);
			sum_y_n = sum_y_q + SUM_W'(points.point_y);
			sum_z_n = sum_z_q + SUM_W'(points.point_z);
			cnt_n   = cnt_q + 1'b1;
		end
	end

	// finished frame goes to the queue
	assign job_valid = xfer && frame_end;
	assign job_data  = {sum_x_n, sum_y_n, sum_z_n, cnt_n, near_cur};

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else if (xfer) begin
			if (frame_end) begin
				found_q <= 1'b0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				cnt_q   <= '0;
			end else begin
				if (search_hit) begin
					found_q <= 1'b1;
				end
				sum_x_q <= sum_x_n;
				sum_y_q <= sum_y_n;
				sum_z_q <= sum_z_n;
				cnt_q   <= cnt_n;
			end
		end
	end

	// nearest depth value, gated by found_q
	always_ff @(posedge clk) begin
		if (xfer && search_hit) begin
			nearest_q <= points.point_z[DEPTH_W-1:0];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ncc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_queue #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  wr_ready,
	output logic                  rd_valid,
	output logic [WIDTH-1:0]      rd_data,
	input  wire logic             rd_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             push, pop;

	assign wr_ready = (level_q != LVL_W'(DEPTH));
	assign rd_valid = (level_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ncc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_back import ncc_pkg::*; #(
	parameter int CNT_W = 20,
	parameter int SUM_W = 35,
	parameter int JOB_W = 3 * 35 + 20 + 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire logic [JOB_W-1:0] job_data,
	output logic                  job_ready,
	ncc_result_if.source          result
);

	localparam int QW     = COORD_W;
	localparam int STEP_W = $clog2(QW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic [CNT_W-1:0]        cnt_q;
	logic [DEPTH_W-1:0]      near_q;
	logic                    empty_q;
	logic [1:0]              axis_q;
	logic                    load_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        rem_q;
	logic [QW-1:0]           dvd_q;
	logic                    neg_q;
	logic [QW-1:0]           cen_q [3];

	logic                    res_valid_q;
	logic [QW-1:0]           res_x_q, res_y_q, res_z_q;
	logic [COUNT_W-1:0]      res_cnt_q;
	logic [DEPTH_W-1:0]      res_near_q;
	logic                    res_ok_q;

	logic                    pop;
	logic                    cnt_zero;
	logic [CNT_W-1:0]        job_cnt;
	logic signed [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0]        mag;
	logic [CNT_W:0]          trial;
	logic                    fits;
	logic [QW-1:0]           quo_n;
	logic                    out_free;

	assign job_ready = (state_q == ST_IDLE);
	assign pop       = job_valid && job_ready;
	assign job_cnt   = job_data[DEPTH_W +: CNT_W];
	assign cnt_zero  = (job_cnt == '0);
	assign out_free  = !res_valid_q || result.ready;

	// magnitude of the sum on the axis being divided
	assign cur_sum = sum_q[axis_q];
	assign mag     = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);

	// one restoring step: quotient never exceeds 16 bits
	assign trial = {rem_q, dvd_q[QW-1]};
	assign fits  = (trial >= {1'b0, cnt_q});
	assign quo_n = {dvd_q[QW-2:0], fits};

	// frame job registers
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q[0] <= job_data[JOB_W-1 -: SUM_W];
			sum_q[1] <= job_data[JOB_W-1-SUM_W -: SUM_W];
			sum_q[2] <= job_data[JOB_W-1-2*SUM_W -: SUM_W];
			cnt_q    <= job_cnt;
			near_q   <= job_data[DEPTH_W-1:0];
			empty_q  <= cnt_zero;
		end
	end

	// divider sequencer over the three axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			load_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						axis_q  <= '0;
						load_q  <= 1'b1;
						state_q <= cnt_zero ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (load_q) begin
						load_q <= 1'b0;
						step_q <= '0;
					end else if (step_q == STEP_W'(QW - 1)) begin
						if (axis_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							axis_q <= axis_q + 1'b1;
							load_q <= 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			if (load_q) begin
				rem_q <= CNT_W'(mag >> QW);
				dvd_q <= mag[QW-1:0];
				neg_q <= cur_sum[SUM_W-1];
			end else begin
				rem_q <= fits ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
				dvd_q <= quo_n;
				if (step_q == STEP_W'(QW - 1)) begin
					cen_q[axis_q] <= neg_q ? QW'(-quo_n) : quo_n;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_x_q    <= empty_q ? '0 : cen_q[0];
			res_y_q    <= empty_q ? '0 : cen_q[1];
			res_z_q    <= empty_q ? '0 : cen_q[2];
			res_cnt_q  <= empty_q ? '0 : COUNT_W'(cnt_q);
			res_near_q <= empty_q ? '0 : near_q;
			res_ok_q   <= !empty_q;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.centroid_x    = res_x_q;
	assign result.centroid_y    = res_y_q;
	assign result.centroid_z    = res_z_q;
	assign result.point_count   = res_cnt_q;
	assign result.nearest_depth = res_near_q;
	assign result.valid_res     = res_ok_q;

endmodule

`default_nettype wire

### hw/rtl/nearest_cluster_centroid.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest-cluster centroid. Each frame is streamed twice: search points
// (opcode 0) lower the nearest valid depth below max_depth, accumulate points
// (opcode 1) sum x, y, z and count the points strictly inside nearest +/- window;
// the accumulate point flagged last_of_pass closes the frame and yields one
// result with per-axis means truncated toward zero, the count and the nearest
// depth (all zeros and valid_res low when nothing was selected). The point port
// takes one point per clock while the queue has room. Each closed frame is
// divided in the shared restoring divider of the back end (a load and 16 steps
// per axis), and the result is then held in its output register; the back end
// takes no new frame until that result is registered. A queue of QUEUE_DEPTH
// closed frames sits between the two, and the point port stalls while that queue
// is full.
// Control registers (index 0 max_depth, index 1 window) are written through
// cfg_we / cfg_index / cfg_data and take effect on the next point.
module nearest_cluster_centroid import ncc_pkg::*; #(
	parameter int MAX_POINTS  = 524288,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	ncc_point_if.sink                 points,
	ncc_result_if.source              result
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = CNT_W + COORD_W - 1;
	localparam int JOB_W = 3 * SUM_W + CNT_W + DEPTH_W;

	cfg_t             cfg_q;
	logic             job_valid, job_ready;
	logic [JOB_W-1:0] job_data;
	logic             q_valid, q_ready;
	logic [JOB_W-1:0] q_data;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_depth <= MAX_DEPTH_RST;
			cfg_q.window    <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_DEPTH: cfg_q.max_depth <= cfg_data;
				REG_WINDOW:    cfg_q.window    <= cfg_data;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	ncc_front #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W),
		.JOB_W      (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.points    (points),
		.job_valid (job_valid),
		.job_data  (job_data),
		.job_ready (job_ready)
	);

	ncc_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_data  (job_data),
		.wr_ready (job_ready),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.rd_ready (q_ready)
	);

	ncc_back #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W),
		.JOB_W (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_data  (q_data),
		.job_ready (q_ready),
		.result    (result)
	);

endmodule

`default_nettype wire

### hw/rtl/ncc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ncc_checker import ncc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic [15:0]        centroid_x,
	input wire logic [15:0]        centroid_y,
	input wire logic [15:0]        centroid_z,
	input wire logic [COUNT_W-1:0] point_count,
	input wire logic [DEPTH_W-1:0] nearest_depth,
	input wire logic               valid_res
);

	// a stalled result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
		&& $stable(centroid_x) && $stable(centroid_y) && $stable(centroid_z)
		&& $stable(point_count) && $stable(nearest_depth) && $stable(valid_res))
		else $error("result changed while stalled");

	// an empty selection reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> centroid_x == '0 && centroid_y == '0
		&& centroid_z == '0 && point_count == '0 && nearest_depth == '0)
		else $error("empty result carries nonzero fields");

	// a valid result always has selected points
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |-> point_count != '0)
		else $error("valid result with zero count");

	// no result right after reset is released
	a_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("result valid straight out of reset");

endmodule

bind nearest_cluster_centroid ncc_checker u_ncc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.centroid_x    (result.centroid_x),
	.centroid_y    (result.centroid_y),
	.centroid_z    (result.centroid_z),
	.point_count   (result.point_count),
	.nearest_depth (result.nearest_depth),
	.valid_res     (result.valid_res)
);

`default_nettype wire
